// ===== rtl/core/sts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token codes and constants of the source token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 24;
    localparam int MAX_RES         = 3;

    localparam logic [5:0] K_LET    = 6'd0;
    localparam logic [5:0] K_CONST  = 6'd1;
    localparam logic [5:0] K_IF     = 6'd2;
    localparam logic [5:0] K_ELSE   = 6'd3;
    localparam logic [5:0] K_FOR    = 6'd4;
    localparam logic [5:0] K_FUNC   = 6'd5;
    localparam logic [5:0] K_RETURN = 6'd6;
    localparam logic [5:0] K_IN     = 6'd7;
    localparam logic [5:0] K_INT    = 6'd8;
    localparam logic [5:0] K_STRING = 6'd9;
    localparam logic [5:0] K_ASSIGN = 6'd10;
    localparam logic [5:0] K_PLUS   = 6'd11;
    localparam logic [5:0] K_MINUS  = 6'd12;
    localparam logic [5:0] K_SLASH  = 6'd14;
    localparam logic [5:0] K_GT     = 6'd15;
    localparam logic [5:0] K_LT     = 6'd16;
    localparam logic [5:0] K_OR     = 6'd17;
    localparam logic [5:0] K_AND    = 6'd18;
    localparam logic [5:0] K_ARROW  = 6'd19;
    localparam logic [5:0] K_COLON  = 6'd20;
    localparam logic [5:0] K_INC    = 6'd23;
    localparam logic [5:0] K_DEC    = 6'd24;
    localparam logic [5:0] K_LPAREN = 6'd25;
    localparam logic [5:0] K_RPAREN = 6'd26;
    localparam logic [5:0] K_LBRACE = 6'd27;
    localparam logic [5:0] K_RBRACE = 6'd28;
    localparam logic [5:0] K_SEMI   = 6'd29;
    localparam logic [5:0] K_COMMA  = 6'd30;
    localparam logic [5:0] K_IDENT  = 6'd31;
    localparam logic [5:0] K_NUMBER = 6'd32;
    localparam logic [5:0] K_STRLIT = 6'd33;
    localparam logic [5:0] K_NOT    = 6'd34;
    localparam logic [5:0] K_EOF    = 6'd35;
    localparam logic [5:0] K_ERROR  = 6'd36;

    localparam logic [1:0] C_NONE  = 2'd0;
    localparam logic [1:0] C_CHAR  = 2'd1;
    localparam logic [1:0] C_STR   = 2'd2;
    localparam logic [1:0] C_BCOM  = 2'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_mark;
    } t_in;

    typedef struct packed {
        logic [5:0]                 token_kind;
        logic [1:0]                 error_cause;
        logic [OFFSET_BITS_DEF-1:0] token_start;
        logic [LENGTH_BITS_DEF-1:0] token_length;
        logic [LINE_BITS_DEF-1:0]   token_line;
        logic                       last_of_run;
    } t_out;

    // keyword lookup on the packed first six bytes and the word length
    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case (n)
            3'd2: begin
                if (w[15:0] == "if") k = K_IF;
                if (w[15:0] == "in") k = K_IN;
            end
            3'd3: begin
                if (w[23:0] == "let") k = K_LET;
                if (w[23:0] == "for") k = K_FOR;
                if (w[23:0] == "int") k = K_INT;
                if (w[23:0] == "not") k = K_NOT;
            end
            3'd4: begin
                if (w[31:0] == "else") k = K_ELSE;
                if (w[31:0] == "func") k = K_FUNC;
            end
            3'd5: if (w[39:0] == "const") k = K_CONST;
            3'd6: begin
                if (w == "return") k = K_RETURN;
                if (w == "string") k = K_STRING;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_front
// Scanning state machine: takes one byte a cycle while i_take is high and
// produces up to three tokens per request as one bundle for the result queue.
// ----------------------------------------------------------------------------
module sts_front
    import sts_pkg::*;
#(
    parameter int OB = OFFSET_BITS_DEF,
    parameter int LB = LENGTH_BITS_DEF,
    parameter int NB = LINE_BITS_DEF,
    parameter int TW = 6 + 2 + OB + LB + NB
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire t_in                    i_req,
    output logic [1:0]                  o_cnt,
    output logic [MAX_RES-1:0][TW-1:0]  o_tok
);

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_INT, M_DOT, M_FRAC, M_STR, M_PLUS, M_MINUS,
        M_AMP, M_BAR, M_SLASH, M_LCOM, M_BCOM
    } t_mode;

    localparam logic [LB-1:0] LMAX = '1;
    localparam logic [NB-1:0] NMAX = '1;

    t_mode       r_mode, n_mode;
    logic [5:0]  r_kind, n_kind;
    logic [OB-1:0] r_start, n_start, r_pos;
    logic [LB-1:0] r_len, n_len;
    logic [NB-1:0] r_line, n_line;
    logic [47:0] r_word, n_word;
    logic        r_star, n_star;

    logic [1:0]  cnt;
    logic [MAX_RES-1:0][TW-1:0] tok;
    logic [LB-1:0] len_p1, len_p2;
    logic [7:0] c;
    logic is_al, is_dg, do_flush, do_idle;

    assign c = i_req.char_byte;
    assign is_al = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign is_dg = c >= "0" && c <= "9";
    assign len_p1 = (r_len == LMAX) ? LMAX : r_len + 1'b1;
    assign len_p2 = (r_len >= LMAX - 1'b1) ? LMAX : r_len + 2'd2;

    always_comb begin
        logic [5:0] ik;
        logic       ie;
        n_mode = r_mode; n_kind = r_kind; n_start = r_start; n_len = r_len;
        n_line = r_line; n_word = r_word; n_star = r_star;
        cnt = 2'd0; tok = '0;
        do_flush = 1'b0; do_idle = 1'b0;
        ik = K_ERROR; ie = 1'b0;
        if (i_req.end_mark) begin
            do_flush = 1'b1;
        end else begin
            unique case (r_mode)
                M_WORD: if (is_al || is_dg) begin
                    n_len = len_p1;
                    if (r_len < LB'(6)) n_word = {r_word[39:0], c};
                end else do_flush = 1'b1;
                M_INT: if (is_dg) n_len = len_p1;
                    else if (c == ".") n_mode = M_DOT;
                    else do_flush = 1'b1;
                M_DOT: if (is_dg) begin n_len = len_p2; n_mode = M_FRAC; end
                    else do_flush = 1'b1;
                M_FRAC: if (is_dg) n_len = len_p1; else do_flush = 1'b1;
                M_STR: begin
                    n_len = len_p1;
                    if (c == "\"") begin
                        tok[0] = {K_STRLIT, C_NONE, r_start, len_p1, r_line};
                        cnt = 2'd1; n_mode = M_IDLE;
                    end else if (c == 8'h0A && r_line != NMAX) n_line = r_line + 1'b1;
                end
                M_PLUS: if (c == "+") begin
                    tok[0] = {K_INC, C_NONE, r_start, LB'(2), r_line}; cnt = 2'd1;
                    n_mode = M_IDLE;
                end else do_flush = 1'b1;
                M_MINUS: if (c == ">" || c == "-") begin
                    tok[0] = {(c == ">") ? K_ARROW : K_DEC, C_NONE, r_start, LB'(2), r_line};
                    cnt = 2'd1; n_mode = M_IDLE;
                end else do_flush = 1'b1;
                M_AMP: if (c == "&") begin
                    tok[0] = {K_AND, C_NONE, r_start, LB'(2), r_line}; cnt = 2'd1;
                    n_mode = M_IDLE;
                end else do_flush = 1'b1;
                M_BAR: if (c == "|") begin
                    tok[0] = {K_OR, C_NONE, r_start, LB'(2), r_line}; cnt = 2'd1;
                    n_mode = M_IDLE;
                end else do_flush = 1'b1;
                M_SLASH: if (c == "/") n_mode = M_LCOM;
                    else if (c == "*") begin
                        n_mode = M_BCOM; n_len = LB'(2); n_star = 1'b0;
                    end else do_flush = 1'b1;
                M_LCOM: if (c == 8'h0A) do_idle = 1'b1;
                M_BCOM: begin
                    n_len = len_p1;
                    if (r_star && c == "/") begin
                        n_mode = M_IDLE; n_star = 1'b0;
                    end else begin
                        n_star = (c == "*");
                        if (c == 8'h0A && r_line != NMAX) n_line = r_line + 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase
        end
        // flush the held token, and add the end token on an end mark
        if (do_flush) begin
            n_mode = M_IDLE;
            case (r_mode)
                M_WORD: begin
                    tok[0] = {(r_len > LB'(6)) ? K_IDENT : word_kind(r_word, r_len[2:0]),
                              C_NONE, r_start, r_len, r_line};
                    cnt = 2'd1;
                end
                M_INT, M_FRAC, M_PLUS, M_MINUS, M_SLASH: begin
                    tok[0] = {r_kind, C_NONE, r_start, r_len, r_line}; cnt = 2'd1;
                end
                M_DOT: begin
                    tok[0] = {K_NUMBER, C_NONE, r_start, r_len, r_line};
                    tok[1] = {K_ERROR, C_CHAR, r_pos - 1'b1, LB'(1), r_line};
                    cnt = 2'd2;
                end
                M_AMP, M_BAR: begin
                    tok[0] = {K_ERROR, C_CHAR, r_start, LB'(1), r_line}; cnt = 2'd1;
                end
                M_STR: begin
                    tok[0] = {K_ERROR, C_STR, r_start, r_len, r_line}; cnt = 2'd1;
                end
                M_BCOM: begin
                    tok[0] = {K_ERROR, C_BCOM, r_start, r_len, r_line}; cnt = 2'd1;
                end
                default: cnt = 2'd0;
            endcase
            if (i_req.end_mark) begin
                tok[cnt] = {K_EOF, C_NONE, r_pos, LB'(0), r_line};
                cnt = cnt + 1'b1;
            end else do_idle = 1'b1;
        end
        // scan a byte from idle
        if (do_idle) begin
            n_mode = M_IDLE;
            if (is_al || is_dg) begin
                n_mode = is_al ? M_WORD : M_INT;
                n_kind = is_al ? K_IDENT : K_NUMBER;
                n_start = r_pos; n_len = LB'(1);
                if (is_al) n_word = {40'd0, c};
            end else begin
                case (c)
                    8'h20, 8'h0D, 8'h09, 8'h0B: ie = 1'b0;
                    8'h0A: if (r_line != NMAX) n_line = r_line + 1'b1;
                    "+", "-", "&", "|", "/", "\"": begin
                        n_start = r_pos; n_len = LB'(1);
                        case (c)
                            "+": begin n_mode = M_PLUS;  n_kind = K_PLUS; end
                            "-": begin n_mode = M_MINUS; n_kind = K_MINUS; end
                            "&": begin n_mode = M_AMP;   n_kind = K_ERROR; end
                            "|": begin n_mode = M_BAR;   n_kind = K_ERROR; end
                            "/": begin n_mode = M_SLASH; n_kind = K_SLASH; end
                            default: begin n_mode = M_STR; n_kind = K_STRLIT; end
                        endcase
                    end
                    "(": begin ik = K_LPAREN; ie = 1'b1; end
                    ")": begin ik = K_RPAREN; ie = 1'b1; end
                    "{": begin ik = K_LBRACE; ie = 1'b1; end
                    "}": begin ik = K_RBRACE; ie = 1'b1; end
                    ";": begin ik = K_SEMI;   ie = 1'b1; end
                    ",": begin ik = K_COMMA;  ie = 1'b1; end
                    ":": begin ik = K_COLON;  ie = 1'b1; end
                    "=": begin ik = K_ASSIGN; ie = 1'b1; end
                    "<": begin ik = K_LT;     ie = 1'b1; end
                    ">": begin ik = K_GT;     ie = 1'b1; end
                    default: begin ik = K_ERROR; ie = 1'b1; end
                endcase
                if (ie) begin
                    tok[cnt] = {ik, (ik == K_ERROR) ? C_CHAR : C_NONE, r_pos, LB'(1),
                                n_line};
                    cnt = cnt + 1'b1;
                end
            end
        end
    end

    assign o_cnt = cnt;
    assign o_tok = tok;

    // advance scanner state on each accepted request; an end mark clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_kind <= '0; r_start <= '0; r_len <= '0;
            r_pos <= '0; r_line <= NB'(1); r_word <= '0; r_star <= 1'b0;
        end else if (i_take) begin
            if (i_req.end_mark) begin
                r_mode <= M_IDLE; r_kind <= '0; r_start <= '0; r_len <= '0;
                r_pos <= '0; r_line <= NB'(1); r_word <= '0; r_star <= 1'b0;
            end else begin
                r_mode <= n_mode; r_kind <= n_kind; r_start <= n_start;
                r_len <= n_len; r_line <= n_line; r_word <= n_word;
                r_star <= n_star; r_pos <= r_pos + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_back
// Token queue: stores up to three tokens per request and hands them out one
// a cycle while popped, marking the last token of each request.
// ----------------------------------------------------------------------------
module sts_back
    import sts_pkg::*;
#(
    parameter int TW    = 80,
    parameter int DEPTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [1:0]            i_cnt,
    input  wire logic [MAX_RES-1:0][TW-1:0] i_tok,
    output logic                       o_room,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [TW:0]                o_head
);

    localparam int AW = $clog2(DEPTH);

    logic [TW:0]   r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_fill;
    logic          pop_ok;

    assign o_empty = (r_fill == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_room  = r_fill <= (AW+1)'(DEPTH - MAX_RES);
    assign o_head  = r_mem[r_rp];

    // write the request's tokens and advance pointers
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < i_cnt)
                    r_mem[r_wp + AW'(k)] <= {i_tok[k], 2'(k + 1) == i_cnt};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_fill <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + AW'(i_cnt);
            if (pop_ok) r_rp <= r_rp + 1'b1;
            r_fill <= r_fill + (i_wr ? (AW+1)'(i_cnt) : '0) - (AW+1)'(pop_ok);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/source_token_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_token_scanner
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Input channel: push a byte (or an end mark) whenever full is low; one
// request is taken every cycle while full is low. The scanner state machine
// classifies the byte in the same cycle and writes zero to three tokens into
// an eight-entry token queue. Result channel: the oldest token sits on o_res
// while empty is low and leaves on pop. Each token is queued the cycle after
// its request. Full rises while fewer than three queue entries are free, so
// a stalled receiver holds back the source after a few requests and no token
// is lost. Sustained rate is one byte a cycle as long as tokens drain one a
// cycle; a byte that gives several tokens needs one pop per token. Reset,
// and every end mark, returns the scanner to offset 0, line 1.
// ----------------------------------------------------------------------------
module source_token_scanner
    import sts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_in  i_req,
    output logic      empty,
    input  wire logic pop,
    output t_out      o_res
);

    localparam int TW = 8 + OFFSET_BITS_DEF + LENGTH_BITS_DEF + LINE_BITS_DEF;

    logic take, room;
    logic [1:0] cnt;
    logic [MAX_RES-1:0][TW-1:0] tok;
    logic [TW:0] head;

    assign full = !room;
    assign take = push && room;

    sts_front #(.OB(OFFSET_BITS_DEF), .LB(LENGTH_BITS_DEF), .NB(LINE_BITS_DEF),
                .TW(TW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_req(i_req),
        .o_cnt(cnt), .o_tok(tok)
    );

    sts_back #(.TW(TW), .DEPTH(8)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(take), .i_cnt(cnt), .i_tok(tok),
        .o_room(room), .i_pop(pop), .o_empty(empty), .o_head(head)
    );

    assign o_res = head;

endmodule
`default_nettype wire

// ===== verif/sts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker
// Watches both channels of the source token scanner. It scans every accepted
// request with its own copy of the scanner state, queues the tokens that the
// request should give, and compares each popped token field by field.
// ----------------------------------------------------------------------------
module sts_checker
    import sts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire t_in         i_req,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [5:0]  i_token_kind,
    input  wire logic [1:0]  i_error_cause,
    input  wire logic [31:0] i_token_start,
    input  wire logic [15:0] i_token_length,
    input  wire logic [23:0] i_token_line,
    input  wire logic        i_last_of_run,
    output int               o_fails,
    output int               o_pending,
    output int               o_checked,
    output int               o_errors
);

    typedef enum logic [3:0] {
        S_IDLE, S_WORD, S_INT, S_DOT, S_FRAC, S_STR, S_PLUS, S_MINUS,
        S_AMP, S_BAR, S_SLASH, S_LCOM, S_BCOM
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  cause;
        logic [31:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic        last;
    } t_tok;

    t_mode       mode;
    logic [5:0]  held_kind;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [31:0] pos;
    logic [23:0] line_no;
    logic [47:0] word_bytes;
    logic        after_star;

    t_tok tok_q[$];
    t_tok batch[$];
    int   fails;
    int   checked;
    int   errors;

    assign o_fails   = fails;
    assign o_pending = tok_q.size();
    assign o_checked = checked;
    assign o_errors  = errors;

    function automatic logic [15:0] len_add(input logic [15:0] a, input int b);
        logic [16:0] s;
        s = {1'b0, a} + 17'(b);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void line_step();
        if (line_no != 24'hFFFFFF) line_no = line_no + 24'd1;
    endfunction

    function void put(input logic [5:0] k, input logic [1:0] c,
                      input logic [31:0] s, input logic [15:0] n);
        t_tok t;
        if (batch.size() >= MAX_RES) return;
        t.kind = k; t.cause = c; t.start = s; t.len = n; t.line = line_no; t.last = 1'b0;
        batch.push_back(t);
    endfunction

    // exact keyword match on length and collected bytes
    function automatic logic [5:0] keyword_of();
        logic [5:0] k;
        k = K_IDENT;
        case (tok_len)
            16'd2: begin
                if (word_bytes == 48'("if")) k = K_IF;
                if (word_bytes == 48'("in")) k = K_IN;
            end
            16'd3: begin
                if (word_bytes == 48'("let")) k = K_LET;
                if (word_bytes == 48'("for")) k = K_FOR;
                if (word_bytes == 48'("int")) k = K_INT;
                if (word_bytes == 48'("not")) k = K_NOT;
            end
            16'd4: begin
                if (word_bytes == 48'("else")) k = K_ELSE;
                if (word_bytes == 48'("func")) k = K_FUNC;
            end
            16'd5: if (word_bytes == 48'("const")) k = K_CONST;
            16'd6: begin
                if (word_bytes == 48'("return")) k = K_RETURN;
                if (word_bytes == 48'("string")) k = K_STRING;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void open_tok(input t_mode m, input logic [5:0] k, input logic [31:0] p);
        mode = m; held_kind = k; tok_start = p; tok_len = 16'd1;
    endfunction

    // emit what the current mode holds and return to idle
    function void flush_held(input logic [31:0] p);
        case (mode)
            S_WORD: put(keyword_of(), C_NONE, tok_start, tok_len);
            S_INT, S_FRAC, S_PLUS, S_MINUS, S_SLASH: put(held_kind, C_NONE, tok_start, tok_len);
            S_DOT: begin
                put(K_NUMBER, C_NONE, tok_start, tok_len);
                put(K_ERROR, C_CHAR, p - 32'd1, 16'd1);
            end
            S_AMP, S_BAR: put(K_ERROR, C_CHAR, tok_start, 16'd1);
            S_STR: put(K_ERROR, C_STR, tok_start, tok_len);
            S_BCOM: put(K_ERROR, C_BCOM, tok_start, tok_len);
            default: ;
        endcase
        mode = S_IDLE;
    endfunction

    function void scan_fresh(input logic [7:0] c, input logic [31:0] p);
        logic [5:0] k;
        mode = S_IDLE;
        if (is_alpha(c)) begin
            open_tok(S_WORD, K_IDENT, p);
            word_bytes = {40'd0, c};
            return;
        end
        if (is_digit(c)) begin
            open_tok(S_INT, K_NUMBER, p);
            return;
        end
        case (c)
            8'h20, 8'h0D, 8'h09, 8'h0B: return;
            8'h0A: begin line_step(); return; end
            "+": begin open_tok(S_PLUS, K_PLUS, p); return; end
            "-": begin open_tok(S_MINUS, K_MINUS, p); return; end
            "&": begin open_tok(S_AMP, K_ERROR, p); return; end
            "|": begin open_tok(S_BAR, K_ERROR, p); return; end
            "/": begin open_tok(S_SLASH, K_SLASH, p); return; end
            8'h22: begin open_tok(S_STR, K_STRLIT, p); return; end
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            ":": k = K_COLON;
            "=": k = K_ASSIGN;
            "<": k = K_LT;
            ">": k = K_GT;
            default: begin put(K_ERROR, C_CHAR, p, 16'd1); return; end
        endcase
        put(k, C_NONE, p, 16'd1);
    endfunction

    function void pair(input logic [5:0] k);
        put(k, C_NONE, tok_start, 16'd2);
        mode = S_IDLE;
    endfunction

    function void scan_byte(input logic [7:0] c, input logic [31:0] p);
        case (mode)
            S_WORD: if (is_alpha(c) || is_digit(c)) begin
                tok_len = len_add(tok_len, 1);
                if (tok_len <= 16'd6) word_bytes = {word_bytes[39:0], c};
                return;
            end
            S_INT: begin
                if (is_digit(c)) begin tok_len = len_add(tok_len, 1); return; end
                if (c == ".") begin mode = S_DOT; return; end
            end
            S_DOT: if (is_digit(c)) begin
                tok_len = len_add(tok_len, 2);
                mode = S_FRAC;
                return;
            end
            S_FRAC: if (is_digit(c)) begin tok_len = len_add(tok_len, 1); return; end
            S_STR: begin
                tok_len = len_add(tok_len, 1);
                if (c == 8'h22) begin
                    put(K_STRLIT, C_NONE, tok_start, tok_len);
                    mode = S_IDLE;
                end else if (c == 8'h0A) line_step();
                return;
            end
            S_PLUS: if (c == "+") begin pair(K_INC); return; end
            S_MINUS: begin
                if (c == ">") begin pair(K_ARROW); return; end
                if (c == "-") begin pair(K_DEC); return; end
            end
            S_AMP: if (c == "&") begin pair(K_AND); return; end
            S_BAR: if (c == "|") begin pair(K_OR); return; end
            S_SLASH: begin
                if (c == "/") begin mode = S_LCOM; return; end
                if (c == "*") begin
                    mode = S_BCOM; tok_len = 16'd2; after_star = 1'b0;
                    return;
                end
            end
            S_LCOM: begin
                if (c == 8'h0A) scan_fresh(c, p);
                return;
            end
            S_BCOM: begin
                tok_len = len_add(tok_len, 1);
                if (after_star && c == "/") begin
                    mode = S_IDLE; after_star = 1'b0;
                    return;
                end
                after_star = (c == "*");
                if (c == 8'h0A) line_step();
                return;
            end
            default: begin scan_fresh(c, p); return; end
        endcase
        flush_held(p);
        scan_fresh(c, p);
    endfunction

    function void clear_state();
        mode = S_IDLE; held_kind = '0; tok_start = '0; tok_len = '0;
        pos = '0; line_no = 24'd1; word_bytes = '0; after_star = 1'b0;
    endfunction

    // work out the tokens of one request and queue them in order
    function void predict(input t_in r);
        batch.delete();
        if (r.end_mark) begin
            flush_held(pos);
            put(K_EOF, C_NONE, pos, 16'd0);
            clear_state();
        end else begin
            scan_byte(r.char_byte, pos);
            pos = pos + 32'd1;
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) tok_q.push_back(batch[i]);
    endfunction

    initial begin
        fails = 0; checked = 0; errors = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        t_tok got;
        t_tok want;
        if (!i_rst_n) begin
            clear_state();
            tok_q.delete();
        end else begin
            // compare the popped token with the oldest one waiting
            if (i_pop && !i_empty) begin
                got = {i_token_kind, i_error_cause, i_token_start, i_token_length,
                       i_token_line, i_last_of_run};
                if (tok_q.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("%0t: token with none waiting: kind %0d start %0d",
                                 $realtime, got.kind, got.start);
                end else begin
                    want = tok_q.pop_front();
                    checked = checked + 1;
                    if (want.kind == K_ERROR) errors = errors + 1;
                    if (got !== want) begin
                        fails = fails + 1;
                        if (fails <= 10) begin
                            $display("%0t: mismatch exp kind/cause/start/len/line/last",
                                     $realtime);
                            $display("  exp %0d %0d %0d %0d %0d %0d",
                                     want.kind, want.cause, want.start, want.len,
                                     want.line, want.last);
                            $display("  got %0d %0d %0d %0d %0d %0d",
                                     got.kind, got.cause, got.start, got.len,
                                     got.line, got.last);
                        end
                    end
                end
            end
            if (i_push && !i_full) predict(i_req);
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds the source token scanner with source text: a directed program, an
// unterminated block comment, then random token snippets mixed with noise
// bytes and end marks, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import sts_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in         i_req;
    logic        empty;
    logic        pop;
    t_out        res;
    int          fails;
    int          pending;
    int          checked;
    int          errors;
    int          sent;

    string snippets[] = '{
        "let", "const", "if", "else", "for", "func", "return", "in", "int",
        "string", "not", "lets", "i", "x_9", "returns", "Int", "abcdefghij",
        "12", "3.25", "7.", "0", "99.x", "\"ab\nc\"", "\"\"", "// note\n",
        "/* a*b\n**/", "(", ")", "{", "}", ";", ",", ":", "+", "++", "-",
        "->", "--", "=", "<", ">", "&&", "||", "/", "&x", "|", "!", "*",
        "1.2.3", "+-", "/x"
    };

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    source_token_scanner u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_res(res)
    );

    sts_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full), .i_req(i_req),
        .i_empty(empty), .i_pop(pop), .i_token_kind(res.token_kind),
        .i_error_cause(res.error_cause), .i_token_start(res.token_start),
        .i_token_length(res.token_length), .i_token_line(res.token_line),
        .i_last_of_run(res.last_of_run), .o_fails(fails), .o_pending(pending),
        .o_checked(checked), .o_errors(errors)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // hand one request to the scanner, after an optional gap
    task automatic send(input logic [7:0] b, input logic em, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req <= '{char_byte: b, end_mark: em};
        do @(posedge i_clk); while (full);
        sent = sent + 1;
    endtask

    task automatic send_text(input string s, input bit gaps);
        for (int i = 0; i < s.len(); i++) send(s[i], 1'b0, gaps ? gap_len() : 0);
    endtask

    task automatic send_sep();
        case ($urandom_range(0, 6))
            0: send(8'h20, 1'b0, gap_len());
            1: send(8'h09, 1'b0, gap_len());
            2: send(8'h0A, 1'b0, gap_len());
            3: send(8'h0D, 1'b0, gap_len());
            4: send(8'h0B, 1'b0, gap_len());
            default: ;
        endcase
    endtask

    // receiver: bursts of pop with idle gaps of random length
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if ($urandom_range(0, 3) != 0) begin
                pop <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int pick;
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_req   = '0;
        sent    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: keywords, operators, fraction, dot error, lone bar, zero byte, unterminated string
        send_text("let x=1.5;7.a|b", 1'b1);
        send(8'h00, 1'b0, 0);
        send(8'hFF, 1'b0, 0);
        send(8'h00, 1'b1, 0);
        send_text("\"ab", 1'b0);
        send(8'h00, 1'b1, 0);

        // hold the source until every token has come out
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        // unterminated block comment full of stars
        send_text("/*", 1'b0);
        for (int i = 0; i < 20; i++) send(8'h2A, 1'b0, 0);
        send(8'h00, 1'b1, 0);

        // random snippets, noise bytes, broken tokens and end marks
        while (sent < 330) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) send(8'($urandom_range(0, 255)), 1'b0, gap_len());
            else if (pick < 12) send(8'($urandom_range(0, 255)), 1'b1, gap_len());
            else if (pick < 14) begin
                send_text($urandom_range(0, 1) ? "\"x y" : "/* x", 1'b1);
                send(8'h00, 1'b1, 0);
            end else begin
                send_text(snippets[$urandom_range(0, snippets.size() - 1)], 1'b1);
                send_sep();
            end
        end
        send(8'h00, 1'b1, 0);
        push <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests; checked %0d tokens, %0d of them error tokens.",
                 sent, checked, errors);
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
